@@ hw/rtl/psv_pkg.sv @@
`timescale 1ns / 1ps

package psv_pkg;

    localparam int DEF_VOICES      = 8;
    localparam int DEF_SAMPLE_RATE = 48000;
    localparam int DEF_SINE_DEPTH  = 1024;
    localparam int DEF_SOURCES     = 2;

    localparam int NOTE_COUNT = 128;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Envelope divider widths.
    localparam int DIV_N_W = 40;
    localparam int DIV_D_W = 16;
    localparam int DIV_Q_W = 24;

    localparam logic [23:0] ENV_FULL  = 24'd8388608;
    localparam logic [15:0] GAIN_FULL = 16'd32768;
    localparam logic [15:0] GAIN_MIN  = 16'd1638;
    localparam logic [14:0] COEFF_MIN = 15'd33;
    localparam logic [14:0] COEFF_MAX = 15'd32440;

    localparam logic [15:0] DEF_ATTACK  = 16'd1757;
    localparam logic [15:0] DEF_DECAY   = 16'd5237;
    localparam logic [23:0] DEF_SUSTAIN = 24'd5200937;
    localparam logic [23:0] DEF_RELEASE = 24'd1173;
    localparam logic [14:0] DEF_COEFF   = 15'd32440;
    localparam logic [15:0] DEF_SCALE   = 16'd26214;
    localparam logic [15:0] DEF_PAN     = 16'd0;
    localparam logic [31:0] DEF_SOURCE  = 32'h8400_2C00;

    localparam logic [31:0] OCTAVE_BASE [12] = '{
        32'd137167144, 32'd145323527, 32'd153964914, 32'd163120144,
        32'd172819772, 32'd183096171, 32'd193983636, 32'd205518503,
        32'd217739269, 32'd230686720, 32'd244404066, 32'd258937088
    };

    localparam logic [63:0] SINE_POLY [5] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995, 64'd172272
    };

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_SUSTAIN = 3'd2,
        REG_RELEASE = 3'd3,
        REG_COEFF   = 3'd4,
        REG_SCALE   = 3'd5,
        REG_PAN     = 3'd6,
        REG_SOURCE  = 3'd7
    } t_reg;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_ON      = 2'd1,
        KIND_OFF     = 2'd2,
        KIND_ALL_OFF = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        W_NONE   = 3'd0,
        W_SINE   = 3'd1,
        W_SAW    = 3'd2,
        W_SQUARE = 3'd3,
        W_TRI    = 3'd4
    } t_wave;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EVT,
        S_SCAN,
        S_START,
        S_V_LOAD,
        S_ENV,
        S_DEC_DIV,
        S_DIV_WAIT,
        S_SIN_A,
        S_SIN_B,
        S_SRC0,
        S_SRC1,
        S_MIX,
        S_FILT_MUL,
        S_FILT,
        S_SCALE,
        S_LVL,
        S_GAIN,
        S_ACC,
        S_V_NEXT,
        S_OUT_L,
        S_OUT_R,
        S_OUT_W
    } t_state;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } t_div_req;

    function automatic logic signed [15:0] osc_sample(
        input logic [2:0]         wave,
        input logic [31:0]        ph,
        input logic signed [15:0] sine
    );
        logic [15:0]        u;
        logic signed [18:0] tri_v;
        logic signed [15:0] res;
        u     = ph[31:16];
        tri_v = '0;
        res   = '0;
        case (t_wave'(wave))
            W_SINE:   res = sine;
            W_SAW:    res = signed'(u);
            W_SQUARE: res = (ph <= 32'h8000_0000) ? 16'sd32767 : -16'sd32767;
            W_TRI: begin
                if (u < 16'd16384) begin
                    res = signed'({u[14:0], 1'b0});
                end else if (u < 16'd49152) begin
                    tri_v = 19'sd65536 - signed'({2'b00, u, 1'b0});
                    res = (tri_v > 19'sd32767) ? 16'sd32767 : tri_v[15:0];
                end else begin
                    tri_v = signed'({2'b00, u, 1'b0}) - 19'sd131072;
                    res = tri_v[15:0];
                end
            end
            default:  res = '0;
        endcase
        return res;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
        if (v > 41'sd32767) begin
            return 16'sd32767;
        end else if (v < -41'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

@@ hw/rtl/psv_mul.sv @@
`timescale 1ns / 1ps

module psv_mul
    import psv_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

@@ hw/rtl/psv_div.sv @@
`timescale 1ns / 1ps

module psv_div
    import psv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    output logic               o_done,
    output logic [DIV_Q_W-1:0] o_quot
);

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the quotient fits in DIV_Q_W bits.
    logic               r_busy;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_Q_W-1:0] r_q;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    assign trial = {r_rem, r_q[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_Q_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num[DIV_N_W-1 -: DIV_D_W];
            r_q   <= i_req.num[DIV_Q_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= ge ? DIV_D_W'(trial - {1'b0, r_den}) : trial[DIV_D_W-1:0];
            r_q   <= {r_q[DIV_Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ hw/rtl/psv_sine_rom.sv @@
`timescale 1ns / 1ps

module psv_sine_rom
    import psv_pkg::*;
#(
    parameter int DEPTH = DEF_SINE_DEPTH
) (
    input  logic                       i_clk,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic signed [15:0]         o_data
);

    logic signed [15:0] rom_tab [DEPTH];
    logic signed [15:0] r_data;

    // Each entry comes from a ninth-order quarter-wave polynomial in Q30.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_rom
        localparam logic [63:0] Q4   = 64'(4 * gi);
        localparam logic [63:0] QUAD = Q4 / 64'(DEPTH);
        localparam logic [63:0] RM   = Q4 - QUAD * 64'(DEPTH);
        localparam logic [63:0] X0   = (RM << 30) / 64'(DEPTH);
        localparam logic [63:0] X    = QUAD[0] ? (64'd1 << 30) - X0 : X0;
        localparam logic [63:0] X2   = (X * X) >> 30;
        localparam logic [63:0] S3   = SINE_POLY[3] - ((X2 * SINE_POLY[4]) >> 30);
        localparam logic [63:0] S2   = SINE_POLY[2] - ((X2 * S3) >> 30);
        localparam logic [63:0] S1   = SINE_POLY[1] - ((X2 * S2) >> 30);
        localparam logic [63:0] S0   = SINE_POLY[0] - ((X2 * S1) >> 30);
        localparam logic [63:0] Y0   = (((X * S0) >> 30) + 64'd16384) >> 15;
        localparam logic [15:0] Y    = (Y0 > 64'd32767) ? 16'd32767 : Y0[15:0];
        localparam logic [15:0] V    = (QUAD >= 64'd2) ? 16'd0 - Y : Y;
        assign rom_tab[gi] = signed'(V);
    end

    always_ff @(posedge i_clk) begin
        r_data <= rom_tab[i_addr];
    end

    assign o_data = r_data;

endmodule

@@ hw/rtl/polyphonic_synth_voice_engine.sv @@
`timescale 1ns / 1ps
// Channel   Signals                                      Direction
// event     i_valid/o_ready, i_kind, i_note, i_velocity  in
// sample    o_valid/i_ready, o_left_sample, o_right_sample out
// config    i_cfg_we, i_cfg_index, i_cfg_data            in
//
// A tick visits every voice in turn; a voice in attack or decay also waits on the serial
// envelope divider. One multiplier serves every product of the datapath.
// Reset is synchronous; it clears all voices and loads the register defaults.
// A finished sample waits in the output register; the next event beat is taken
// meanwhile, and a tick stalls only at its own output until the register frees.

module polyphonic_synth_voice_engine
    import psv_pkg::*;
#(
    parameter int VOICES           = DEF_VOICES,
    parameter int SAMPLE_RATE      = DEF_SAMPLE_RATE,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_DEPTH,
    parameter int SOURCES          = DEF_SOURCES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [6:0]         i_note,
    input  logic [6:0]         i_velocity,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SUM_W = 23 + VW;
    localparam int AW    = $clog2(SINE_TABLE_DEPTH);

    // Per-note phase step and velocity gain tables.
    logic [31:0] step_tab [NOTE_COUNT];
    logic [15:0] gain_tab [NOTE_COUNT];

    for (genvar gn = 0; gn < NOTE_COUNT; gn++) begin : g_note
        localparam logic [63:0] FQ = 64'(OCTAVE_BASE[gn % 12]) << (gn / 12);
        localparam logic [63:0] ST =
            (FQ * 64'd256 + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
        localparam logic [63:0] GR = (64'(gn) * 64'd32768 + 64'd63) / 64'd127;
        localparam logic [15:0] GC = (GR < 64'(GAIN_MIN)) ? GAIN_MIN :
                                     (GR > 64'(GAIN_FULL)) ? GAIN_FULL : GR[15:0];
        assign step_tab[gn] = ST[31:0];
        assign gain_tab[gn] = GC;
    end

    // Configuration registers.
    logic [15:0]        r_attack;
    logic [15:0]        r_decay;
    logic [23:0]        r_sustain;
    logic [23:0]        r_release;
    logic [14:0]        r_coeff;
    logic [15:0]        r_scale;
    logic signed [15:0] r_pan;
    logic [31:0]        r_source;

    // Voice state.
    logic               r_v_active [VOICES];
    logic               r_v_held   [VOICES];
    logic [6:0]         r_v_note   [VOICES];
    logic [23:0]        r_v_level  [VOICES];
    logic [31:0]        r_v_phase  [VOICES];
    logic [15:0]        r_v_gain   [VOICES];
    logic [31:0]        r_v_age    [VOICES];
    logic signed [19:0] r_v_filter [VOICES];

    // Sequencer and working registers.
    t_state             r_state;
    t_state             n_state;
    t_kind              r_kind;
    logic [6:0]         r_note;
    logic [6:0]         r_vel;
    logic [VW-1:0]      r_vidx;
    logic [VW-1:0]      r_pick;
    logic [31:0]        r_ph;
    logic [23:0]        r_lvl;
    logic [31:0]        r_age;
    logic [15:0]        r_gain;
    logic signed [19:0] r_flt;
    logic               r_held;
    logic               r_env_dec;
    logic signed [29:0] r_mix;
    logic signed [21:0] r_diff;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [15:0] r_left;
    logic               r_out_valid;
    logic signed [15:0] r_out_left;
    logic signed [15:0] r_out_right;

    // Shared units.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] r_prod;
    t_div_req                  div_req;
    logic                      div_done;
    logic [DIV_Q_W-1:0]        div_q;
    logic [AW-1:0]             rom_addr;
    logic signed [15:0]        rom_data;

    psv_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    psv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    psv_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    // Effective register values.
    logic [15:0]        att_eff;
    logic [15:0]        dec_eff;
    logic [23:0]        sus_eff;
    logic [23:0]        rel_eff;
    logic [14:0]        coeff_eff;
    logic [16:0]        pan_lg;
    logic [16:0]        pan_rg;
    logic [12:0]        src_lvl0;
    logic [12:0]        src_lvl1;
    logic               env_att;
    logic               env_dec;
    logic               last_voice;
    logic               scan_hit;
    logic               accept;
    logic               out_free;
    logic signed [15:0] osc0;
    logic signed [15:0] osc1;
    logic signed [30:0] mix_sum;
    logic signed [30:0] mix_m;
    logic signed [21:0] diff_new;
    logic signed [19:0] flt_new;

    assign att_eff   = (r_attack == 16'd0) ? 16'd1 : r_attack;
    assign dec_eff   = (r_decay == 16'd0) ? 16'd1 : r_decay;
    assign sus_eff   = (r_sustain > ENV_FULL) ? ENV_FULL : r_sustain;
    assign rel_eff   = (r_release == 24'd0) ? ENV_FULL : r_release;
    assign coeff_eff = (r_coeff < COEFF_MIN) ? COEFF_MIN :
                       (r_coeff > COEFF_MAX) ? COEFF_MAX : r_coeff;
    assign pan_lg    = (r_pan > 16'sd0) ? 17'd32768 - 17'(unsigned'(r_pan)) : 17'd32768;
    assign pan_rg    = (r_pan < 16'sd0) ? 17'd32768 + 17'(r_pan) : 17'd32768;
    assign src_lvl0  = r_source[12:0];
    assign src_lvl1  = (SOURCES > 1) ? r_source[28:16] : 13'd0;

    assign env_att    = r_age < 32'(att_eff);
    assign env_dec    = r_age < 32'({1'b0, att_eff} + {1'b0, dec_eff});
    assign last_voice = r_vidx == VW'(VOICES - 1);
    assign scan_hit   = !r_v_active[r_vidx] || (r_v_level[r_vidx] == 24'd0);
    assign accept     = i_valid && o_ready;
    assign out_free   = !r_out_valid || i_ready;

    assign osc0     = osc_sample(r_source[15:13], r_ph, rom_data);
    assign osc1     = osc_sample(r_source[31:29], r_ph, rom_data);
    assign mix_sum  = 31'(r_mix) + 31'(signed'(r_prod[29:0]));
    assign mix_m    = mix_sum >>> 10;
    assign diff_new = 22'(mix_m) - 22'(r_flt);
    assign flt_new  = 20'(22'(r_flt) + 22'(r_prod >>> 15));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (accept) n_state = S_EVT;
            S_EVT: begin
                case (r_kind)
                    KIND_TICK: n_state = S_V_LOAD;
                    KIND_ON:   n_state = (r_vel == 7'd0) ? S_IDLE : S_SCAN;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SCAN:     if (scan_hit || last_voice) n_state = S_START;
            S_START:    n_state = S_IDLE;
            S_V_LOAD:   n_state = r_v_active[r_vidx] ? S_ENV : S_V_NEXT;
            S_ENV: begin
                if (r_held) begin
                    if (env_att) begin
                        n_state = S_DIV_WAIT;
                    end else if (env_dec) begin
                        n_state = S_DEC_DIV;
                    end else begin
                        n_state = S_SIN_A;
                    end
                end else begin
                    n_state = (r_lvl > rel_eff) ? S_SIN_A : S_V_NEXT;
                end
            end
            S_DEC_DIV:  n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (div_done) n_state = S_SIN_A;
            S_SIN_A:    n_state = S_SIN_B;
            S_SIN_B:    n_state = S_SRC0;
            S_SRC0:     n_state = S_SRC1;
            S_SRC1:     n_state = S_MIX;
            S_MIX:      n_state = S_FILT_MUL;
            S_FILT_MUL: n_state = S_FILT;
            S_FILT:     n_state = S_SCALE;
            S_SCALE:    n_state = S_LVL;
            S_LVL:      n_state = S_GAIN;
            S_GAIN:     n_state = S_ACC;
            S_ACC:      n_state = S_V_NEXT;
            S_V_NEXT:   n_state = last_voice ? S_OUT_L : S_V_LOAD;
            S_OUT_L:    n_state = S_OUT_R;
            S_OUT_R:    n_state = S_OUT_W;
            S_OUT_W:    if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Unit controls: multiplier operands, divider request, sine address.
    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        div_req     = '0;
        rom_addr    = r_prod[32 +: AW];
        o_ready     = r_state == S_IDLE;
        case (r_state)
            S_ENV: begin
                if (r_held && env_att) begin
                    div_req.start = 1'b1;
                    div_req.num   = DIV_N_W'({r_age[15:0], 23'd0});
                    div_req.den   = att_eff;
                end
                mul_a = MUL_A_W'(16'(r_age - 32'(att_eff)));
                mul_b = MUL_B_W'(ENV_FULL - sus_eff);
            end
            S_DEC_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = r_prod[DIV_N_W-1:0];
                div_req.den   = dec_eff;
            end
            // The table address is held for two reads, one for each source.
            S_SIN_A, S_SIN_B: begin
                mul_a = MUL_A_W'(r_ph);
                mul_b = MUL_B_W'(SINE_TABLE_DEPTH);
            end
            S_SRC0: begin
                mul_a = MUL_A_W'(osc0);
                mul_b = MUL_B_W'(src_lvl0);
            end
            S_SRC1: begin
                mul_a = MUL_A_W'(osc1);
                mul_b = MUL_B_W'(src_lvl1);
            end
            S_FILT_MUL: begin
                mul_a = MUL_A_W'(r_diff);
                mul_b = MUL_B_W'(coeff_eff);
            end
            S_SCALE: begin
                mul_a = MUL_A_W'(r_flt);
                mul_b = MUL_B_W'(r_scale);
            end
            S_LVL: begin
                mul_a = MUL_A_W'(r_prod >>> 15);
                mul_b = MUL_B_W'(r_lvl);
            end
            S_GAIN: begin
                mul_a = MUL_A_W'(r_prod >>> 23);
                mul_b = MUL_B_W'(r_gain);
            end
            S_OUT_L: begin
                mul_a = MUL_A_W'(r_sum);
                mul_b = MUL_B_W'(pan_lg);
            end
            // The right product is held through the output wait.
            S_OUT_R, S_OUT_W: begin
                mul_a = MUL_A_W'(r_sum);
                mul_b = MUL_B_W'(pan_rg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= DEF_ATTACK;
            r_decay   <= DEF_DECAY;
            r_sustain <= DEF_SUSTAIN;
            r_release <= DEF_RELEASE;
            r_coeff   <= DEF_COEFF;
            r_scale   <= DEF_SCALE;
            r_pan     <= signed'(DEF_PAN);
            r_source  <= DEF_SOURCE;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_ATTACK:  r_attack  <= i_cfg_data[15:0];
                REG_DECAY:   r_decay   <= i_cfg_data[15:0];
                REG_SUSTAIN: r_sustain <= i_cfg_data[23:0];
                REG_RELEASE: r_release <= i_cfg_data[23:0];
                REG_COEFF:   r_coeff   <= i_cfg_data[14:0];
                REG_SCALE:   r_scale   <= i_cfg_data[15:0];
                REG_PAN:     r_pan     <= signed'(i_cfg_data[15:0]);
                REG_SOURCE:  r_source  <= i_cfg_data;
                default:     r_source  <= r_source;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT_W && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT_W && out_free) begin
            r_out_left  <= r_left;
            r_out_right <= sat16(41'(r_prod >>> 17));
        end
    end

    // Voice state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                r_v_active[v] <= 1'b0;
                r_v_held[v]   <= 1'b0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= t_kind'(i_kind);
                        r_note <= i_note;
                        r_vel  <= i_velocity;
                    end
                end
                S_EVT: begin
                    r_vidx <= '0;
                    r_sum  <= '0;
                    case (r_kind)
                        KIND_ON, KIND_OFF: begin
                            // A note on with zero velocity releases like a note off.
                            if (r_kind == KIND_OFF || r_vel == 7'd0) begin
                                for (int v = 0; v < VOICES; v++) begin
                                    if (r_v_active[v] && r_v_note[v] == r_note) begin
                                        r_v_held[v] <= 1'b0;
                                    end
                                end
                            end
                        end
                        KIND_ALL_OFF: begin
                            for (int v = 0; v < VOICES; v++) begin
                                r_v_held[v] <= 1'b0;
                            end
                        end
                        default: r_sum <= '0;
                    endcase
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        r_pick <= r_vidx;
                    end else if (last_voice) begin
                        r_pick <= '0;
                    end else begin
                        r_vidx <= r_vidx + VW'(1);
                    end
                end
                S_START: begin
                    r_v_note[r_pick]   <= r_note;
                    r_v_held[r_pick]   <= 1'b1;
                    r_v_active[r_pick] <= 1'b1;
                    r_v_level[r_pick]  <= '0;
                    r_v_phase[r_pick]  <= '0;
                    r_v_gain[r_pick]   <= gain_tab[r_vel];
                    r_v_age[r_pick]    <= '0;
                    r_v_filter[r_pick] <= '0;
                end
                S_V_LOAD: begin
                    r_ph   <= r_v_phase[r_vidx] + step_tab[r_v_note[r_vidx]];
                    r_lvl  <= r_v_level[r_vidx];
                    r_age  <= r_v_age[r_vidx];
                    r_gain <= r_v_gain[r_vidx];
                    r_flt  <= r_v_filter[r_vidx];
                    r_held <= r_v_held[r_vidx];
                end
                S_ENV: begin
                    if (r_held) begin
                        r_env_dec <= !env_att;
                        if (!env_att && !env_dec) begin
                            r_lvl <= sus_eff;
                        end
                    end else if (r_lvl > rel_eff) begin
                        r_lvl <= r_lvl - rel_eff;
                    end else begin
                        // The release reached zero, so the voice is freed.
                        r_v_level[r_vidx]  <= '0;
                        r_v_phase[r_vidx]  <= r_ph;
                        r_v_active[r_vidx] <= 1'b0;
                        r_v_note[r_vidx]   <= '0;
                        r_v_gain[r_vidx]   <= GAIN_FULL;
                        r_v_age[r_vidx]    <= '0;
                        r_v_filter[r_vidx] <= '0;
                    end
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_lvl <= r_env_dec ? ENV_FULL - div_q : div_q;
                    end
                end
                S_SRC1:  r_mix  <= r_prod[29:0];
                S_MIX:   r_diff <= diff_new;
                S_FILT:  r_flt  <= flt_new;
                S_ACC: begin
                    r_sum              <= r_sum + SUM_W'(r_prod >>> 15);
                    r_v_phase[r_vidx]  <= r_ph;
                    r_v_level[r_vidx]  <= r_lvl;
                    r_v_filter[r_vidx] <= r_flt;
                    if (r_age != 32'hFFFF_FFFF) begin
                        r_v_age[r_vidx] <= r_age + 32'd1;
                    end
                end
                S_V_NEXT: begin
                    if (!last_voice) begin
                        r_vidx <= r_vidx + VW'(1);
                    end
                end
                S_OUT_R: r_left <= sat16(41'(r_prod >>> 17));
                default: r_env_dec <= r_env_dec;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_left_sample  = r_out_left;
    assign o_right_sample = r_out_right;

`ifndef SYNTH
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV_WAIT)
        else $error("divider finished while the sequencer was not waiting");

    a_sample_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_OUT_W)
        else $error("sample appeared without the output step");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SIN_A |-> r_lvl <= ENV_FULL)
        else $error("envelope level above full scale");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == KIND_TICK) |=> !o_ready)
        else $error("tick beat taken without starting the voice sweep");
`endif

endmodule
